FILE: rtl/srpt_pkg.sv
// Package for the sparse row pattern table: beat types, status and function codes,
// and default sizes. No dependencies; used by every file of the block.
`default_nettype none

package srpt_pkg;

    localparam int DEF_ROWS         = 1024;
    localparam int DEF_ROW_CAPACITY = 32;

    localparam int ROW_IDX_W = 10;
    localparam int COL_W     = 10;
    localparam int POS_W     = 5;
    localparam int LEN_W     = 6;
    localparam int TOTAL_W   = 16;

    typedef enum logic [0:0] {
        FUNC_INSERT = 1'b0,
        FUNC_SEARCH = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_FOUND    = 3'd2,
        ST_MISSING  = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef struct packed {
        func_t                func;
        logic [ROW_IDX_W-1:0] row_index;
        logic [COL_W-1:0]     col_index;
    } req_t;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        status_t            status;
        logic [LEN_W-1:0]   row_length;
        logic [TOTAL_W-1:0] nonzero_total;
    } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/sparse_row_pattern_table_top.sv
// Top level of the sparse row pattern table: column store, row fill memory and the
// scan sequencer that searches and inserts in one pass. Depends on srpt_pkg.
//
//   Channel   Direction   Handshake              Beat type
//   req       in          req_valid / req_ready  srpt_pkg::req_t
//   rsp       out         rsp_valid / rsp_ready  srpt_pkg::rsp_t
//
// Items are taken one at a time: req_ready stays low from acceptance until the result
// is passed to rsp. The scan reads the row slot by slot, up to its fill of at most
// ROW_CAPACITY, and an insert writes each shifted slot back as the next one is read.
// A hit, a search miss or a full row seen before the end of the row ends the scan
// early; a row outside the table skips it. After reset a clearing pass zeroes the
// row fill memory; req_ready stays low during it.
// A stalled rsp holds one result while the next item is accepted and scanned.
`default_nettype none

module sparse_row_pattern_table_top #(
    parameter int ROWS         = srpt_pkg::DEF_ROWS,
    parameter int ROW_CAPACITY = srpt_pkg::DEF_ROW_CAPACITY
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire srpt_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output srpt_pkg::rsp_t      rsp
);

    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int FILL_W = $clog2(ROW_CAPACITY + 1);
    localparam int DEPTH  = ROWS * ROW_CAPACITY;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = srpt_pkg::COL_W;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_FILL  = 5'b00100,
        S_SCAN  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t                         state_reg, state_next;
    logic [ROW_W-1:0]               clr_idx_reg, clr_idx_next;
    srpt_pkg::func_t                func_reg, func_next;
    logic [ROW_W-1:0]               row_reg, row_next;
    logic [COL_W-1:0]               col_reg, col_next;
    logic [ADDR_W-1:0]              base_reg, base_next;
    logic [FILL_W-1:0]              fill_reg, fill_next;
    logic [FILL_W-1:0]              s_reg, s_next;
    logic [FILL_W-1:0]              k_reg, k_next;
    logic                           shifting_reg, shifting_next;
    logic [COL_W-1:0]               carry_reg, carry_next;
    logic [FILL_W-1:0]              res_pos_reg, res_pos_next;
    srpt_pkg::status_t              res_status_reg, res_status_next;
    logic [FILL_W-1:0]              res_len_reg, res_len_next;
    logic [srpt_pkg::TOTAL_W-1:0]   count_reg, count_next;
    logic                           rsp_valid_reg, rsp_valid_next;
    srpt_pkg::rsp_t                 rsp_reg, rsp_next;

    logic [COL_W-1:0]  col_mem [DEPTH];
    logic [FILL_W-1:0] fill_mem [ROWS];
    logic [COL_W-1:0]  col_q;
    logic [FILL_W-1:0] fill_q;

    logic              col_re;
    logic [ADDR_W-1:0] col_raddr;
    logic              col_we;
    logic [ADDR_W-1:0] col_waddr;
    logic [COL_W-1:0]  col_wdata;
    logic              fill_we;
    logic [ROW_W-1:0]  fill_waddr;
    logic [FILL_W-1:0] fill_wdata;

    logic              req_fire;
    logic [31:0]       row_ext;
    logic [ROW_W-1:0]  req_row;
    logic              row_in_range;
    logic [31:0]       base_ext;
    logic [FILL_W-1:0] s_inc;
    logic              at_end;
    logic              row_full;
    logic [31:0]       pos_ext;
    logic [31:0]       len_ext;

    assign req_ready    = (state_reg == S_IDLE);
    assign req_fire     = req_valid && req_ready;
    assign row_ext      = 32'(req.row_index);
    assign req_row      = row_ext[ROW_W-1:0];
    assign row_in_range = (row_ext < 32'(ROWS));
    assign base_ext     = 32'(req_row) * 32'(ROW_CAPACITY);
    assign s_inc        = s_reg + FILL_W'(1);
    assign at_end       = (s_reg == fill_reg);
    assign row_full     = (fill_reg == FILL_W'(ROW_CAPACITY));
    assign pos_ext      = 32'(res_pos_reg);
    assign len_ext      = 32'(res_len_reg);
    assign rsp_valid    = rsp_valid_reg;
    assign rsp          = rsp_reg;

    always_ff @(posedge clk)
    begin
        if (col_we)
        begin
            col_mem[col_waddr] <= col_wdata;
        end
        if (col_re)
        begin
            col_q <= col_mem[col_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        if (req_fire)
        begin
            fill_q <= fill_mem[req_row];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        func_next       = func_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        base_next       = base_reg;
        fill_next       = fill_reg;
        s_next          = s_reg;
        k_next          = k_reg;
        shifting_next   = shifting_reg;
        carry_next      = carry_reg;
        res_pos_next    = res_pos_reg;
        res_status_next = res_status_reg;
        res_len_next    = res_len_reg;
        count_next      = count_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_next        = rsp_reg;
        col_re          = 1'b0;
        col_raddr       = base_reg + ADDR_W'(s_inc);
        col_we          = 1'b0;
        col_waddr       = base_reg + ADDR_W'(s_reg);
        col_wdata       = col_reg;
        fill_we         = 1'b0;
        fill_waddr      = row_reg;
        fill_wdata      = fill_reg + FILL_W'(1);

        unique case (state_reg)
            S_CLEAR:
            begin
                fill_we      = 1'b1;
                fill_waddr   = clr_idx_reg;
                fill_wdata   = '0;
                clr_idx_next = clr_idx_reg + ROW_W'(1);
                if (clr_idx_reg == ROW_W'(ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    func_next     = req.func;
                    row_next      = req_row;
                    col_next      = req.col_index;
                    base_next     = base_ext[ADDR_W-1:0];
                    shifting_next = 1'b0;
                    if (row_in_range)
                    begin
                        state_next = S_FILL;
                    end
                    else
                    begin
                        res_pos_next    = '0;
                        res_len_next    = '0;
                        res_status_next = (req.func == srpt_pkg::FUNC_SEARCH) ?
                                          srpt_pkg::ST_MISSING : srpt_pkg::ST_FULL;
                        state_next      = S_DONE;
                    end
                end
            end
            S_FILL:
            begin
                fill_next  = fill_q;
                s_next     = '0;
                col_re     = 1'b1;
                col_raddr  = base_reg;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                res_len_next = fill_reg;
                res_pos_next = '0;
                if (at_end)
                begin
                    state_next = S_DONE;
                    if (shifting_reg || (func_reg == srpt_pkg::FUNC_INSERT && !row_full))
                    begin
                        col_we          = 1'b1;
                        col_wdata       = shifting_reg ? carry_reg : col_reg;
                        fill_we         = 1'b1;
                        res_pos_next    = shifting_reg ? k_reg : s_reg;
                        res_len_next    = fill_reg + FILL_W'(1);
                        res_status_next = srpt_pkg::ST_INSERTED;
                        if (count_reg != '1)
                        begin
                            count_next = count_reg + srpt_pkg::TOTAL_W'(1);
                        end
                    end
                    else if (func_reg == srpt_pkg::FUNC_SEARCH)
                    begin
                        res_status_next = srpt_pkg::ST_MISSING;
                    end
                    else
                    begin
                        res_status_next = srpt_pkg::ST_FULL;
                    end
                end
                else if (shifting_reg)
                begin
                    col_we     = 1'b1;
                    col_wdata  = carry_reg;
                    carry_next = col_q;
                    s_next     = s_inc;
                    col_re     = (s_inc < fill_reg);
                end
                else if (col_q < col_reg)
                begin
                    s_next = s_inc;
                    col_re = (s_inc < fill_reg);
                end
                else if (col_q == col_reg)
                begin
                    res_pos_next    = s_reg;
                    res_status_next = (func_reg == srpt_pkg::FUNC_SEARCH) ?
                                      srpt_pkg::ST_FOUND : srpt_pkg::ST_PRESENT;
                    state_next      = S_DONE;
                end
                else if (func_reg == srpt_pkg::FUNC_SEARCH)
                begin
                    res_status_next = srpt_pkg::ST_MISSING;
                    state_next      = S_DONE;
                end
                else if (row_full)
                begin
                    res_status_next = srpt_pkg::ST_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    col_we        = 1'b1;
                    col_wdata     = col_reg;
                    carry_next    = col_q;
                    shifting_next = 1'b1;
                    k_next        = s_reg;
                    s_next        = s_inc;
                    col_re        = (s_inc < fill_reg);
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.position      = pos_ext[srpt_pkg::POS_W-1:0];
                    rsp_next.status        = res_status_reg;
                    rsp_next.row_length    = len_ext[srpt_pkg::LEN_W-1:0];
                    rsp_next.nonzero_total = count_reg;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            shifting_reg  <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            shifting_reg  <= shifting_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        row_reg        <= row_next;
        col_reg        <= col_next;
        base_reg       <= base_next;
        fill_reg       <= fill_next;
        s_reg          <= s_next;
        k_reg          <= k_next;
        carry_reg      <= carry_next;
        res_pos_reg    <= res_pos_next;
        res_status_reg <= res_status_next;
        res_len_reg    <= res_len_next;
        rsp_reg        <= rsp_next;
    end

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= $past(count_reg))
        else $error("Nonzero count decreased.");

    a_scan_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (s_reg <= fill_reg && fill_reg <= FILL_W'(ROW_CAPACITY)))
        else $error("Scan slot left the filled part of the row.");

    a_store_write_insert: assert property (@(posedge clk) disable iff (!rst_n)
        col_we |-> (state_reg == S_SCAN && func_reg == srpt_pkg::FUNC_INSERT))
        else $error("Column store written outside an insert scan.");

    a_fill_grows_once: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_we && state_reg == S_SCAN) |=>
            (state_reg == S_DONE && res_status_reg == srpt_pkg::ST_INSERTED
             && count_reg != '0))
        else $error("Row fill grew without a counted insert.");

endmodule

`default_nettype wire
